// ===== rtl/core/oett_pkg.sv =====
// Package for the outstanding event timeout tracker.
// Types, codes and constants shared by controller, datapath and top level.
package oett_pkg;

  localparam int unsigned LIST_DEPTH_DEF = 16;
  localparam int unsigned MAX_RESULTS    = 16;
  localparam logic [31:0] TIMEOUT_RESET  = 32'd1000;

  localparam logic [1:0] REQ_DISPATCH = 2'd0;
  localparam logic [1:0] REQ_TICK     = 2'd1;
  localparam logic [1:0] REQ_COMPLETE = 2'd2;
  localparam logic [1:0] REQ_LINK_ERR = 2'd3;

  localparam logic [2:0] RES_PROCESS  = 3'd0;
  localparam logic [2:0] RES_BUILD    = 3'd1;
  localparam logic [2:0] RES_REASSIGN = 3'd2;
  localparam logic [2:0] RES_CLEAR    = 3'd3;
  localparam logic [2:0] RES_UNKNOWN  = 3'd4;
  localparam logic [2:0] RES_REQUEST  = 3'd5;
  localparam logic [2:0] RES_REFUSED  = 3'd6;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] event_id;
    logic        was_reassigned;
    logic        last_of_message;
    logic [15:0] requested_count;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [31:0] result_id;
    logic [31:0] latency_ticks;
    logic [15:0] request_count;
    logic [15:0] ids_in_message;
    logic        last_result;
  } out_beat_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_APPEND,
    CMD_TICK,
    CMD_SCAN_START,
    CMD_SCAN_STEP,
    CMD_REMOVE_STEP,
    CMD_POP,
    CMD_SET_ERROR,
    CMD_MSG_COUNT,
    CMD_MSG_CLEAR
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic in_error;
    logic front_expired;
    logic scan_hit;
    logic scan_end;
    logic remove_done;
  } dp_status_t;

endpackage

// ===== rtl/core/oett_datapath.sv =====
// Datapath of the outstanding event tracker: entry memory, counters, time.
// Depends on oett_pkg; commanded by oett_ctrl.
module oett_datapath #(
  parameter int unsigned LIST_DEPTH = oett_pkg::LIST_DEPTH_DEF,
  localparam int unsigned IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  oett_pkg::dp_cmd_t   cmd,
  input  oett_pkg::in_beat_t  in_beat,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_data,
  output oett_pkg::dp_status_t status,
  output logic [31:0]         item_id,
  output logic [31:0]         front_id,
  output logic [31:0]         latency,
  output logic [15:0]         msg_count,
  output logic                item_reassigned,
  output logic                item_last,
  output logic [15:0]         item_req,
  output logic [1:0]          item_type
);
  import oett_pkg::*;

  logic [31:0] ids_mem   [LIST_DEPTH];
  logic [31:0] times_mem [LIST_DEPTH];

  in_beat_t    item_r;
  logic [CW-1:0] count_r;
  logic [31:0] tick_r;
  logic [31:0] timeout_r;
  logic        err_r;
  logic [15:0] msg_r;
  logic [IW-1:0] pos_r;
  logic [31:0] rd_id_r;
  logic [31:0] rd_time_r;
  logic [31:0] front_time_r;
  logic [31:0] front_id_r;

  logic [CW-1:0] pos_ext;
  logic [CW-1:0] pos_p1;
  logic [IW-1:0] rd_addr;

  assign pos_ext = CW'(pos_r);
  assign pos_p1  = pos_ext + CW'(1);
  assign rd_addr = IW'(pos_p1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      tick_r    <= '0;
      timeout_r <= TIMEOUT_RESET;
      err_r     <= 1'b0;
      msg_r     <= '0;
      pos_r     <= '0;
    end else begin
      if (cfg_we) timeout_r <= cfg_data;
      case (cmd.cmd)
        CMD_LOAD: item_r <= in_beat;
        CMD_APPEND: begin
          ids_mem[IW'(count_r)]   <= item_r.event_id;
          times_mem[IW'(count_r)] <= tick_r;
          count_r <= count_r + CW'(1);
        end
        CMD_TICK: tick_r <= tick_r + 32'd1;
        CMD_SCAN_START: begin
          pos_r     <= '0;
          rd_id_r   <= ids_mem[0];
          rd_time_r <= times_mem[0];
        end
        CMD_SCAN_STEP: begin
          pos_r     <= IW'(pos_p1);
          rd_id_r   <= ids_mem[rd_addr];
          rd_time_r <= times_mem[rd_addr];
        end
        CMD_REMOVE_STEP: begin
          if (pos_p1 < count_r) begin
            ids_mem[pos_r]   <= ids_mem[rd_addr];
            times_mem[pos_r] <= times_mem[rd_addr];
            pos_r <= IW'(pos_p1);
          end else begin
            count_r <= count_r - CW'(1);
          end
        end
        CMD_POP: pos_r <= '0;
        CMD_SET_ERROR: err_r <= 1'b1;
        CMD_MSG_COUNT: if (msg_r != 16'hFFFF) msg_r <= msg_r + 16'd1;
        CMD_MSG_CLEAR: msg_r <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    front_id_r   <= ids_mem[0];
    front_time_r <= times_mem[0];
  end

  always_comb begin
    status.empty         = (count_r == '0);
    status.full          = (count_r >= CW'(LIST_DEPTH));
    status.in_error      = err_r;
    status.front_expired = ((tick_r - front_time_r) >= timeout_r);
    status.scan_hit      = (rd_id_r == item_r.event_id);
    status.scan_end      = (pos_p1 >= count_r);
    status.remove_done   = (pos_p1 >= count_r);
  end

  assign item_id         = item_r.event_id;
  assign front_id        = front_id_r;
  assign latency         = tick_r - rd_time_r;
  assign msg_count       = msg_r;
  assign item_reassigned = item_r.was_reassigned;
  assign item_last       = item_r.last_of_message;
  assign item_req        = item_r.requested_count;
  assign item_type       = item_r.req_type;

endmodule

// ===== rtl/core/oett_ctrl.sv =====
// Controller of the outstanding event tracker: sequences each input beat.
// Depends on oett_pkg; drives oett_datapath and the output register.
module oett_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output oett_pkg::out_beat_t  out_data,
  output oett_pkg::dp_cmd_t    cmd,
  input  oett_pkg::dp_status_t status,
  input  logic [31:0]          item_id,
  input  logic [31:0]          front_id,
  input  logic [31:0]          latency,
  input  logic [15:0]          msg_count,
  input  logic                 item_reassigned,
  input  logic                 item_last,
  input  logic [15:0]          item_req,
  input  logic [1:0]           item_type
);
  import oett_pkg::*;

  localparam int unsigned NW = $clog2(MAX_RESULTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_POP_WAIT, S_POP_TEST, S_POP_SHIFT,
    S_SCAN_WAIT, S_SCAN_TEST, S_REMOVE, S_REQ, S_EMIT
  } state_t;

  state_t    state_r, state_nxt, ret_r, ret_nxt;
  out_beat_t out_r, out_nxt;
  out_beat_t hold_r, hold_nxt;
  logic      out_v_r, out_v_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic      force_r, force_nxt;
  dp_cmd_t   cmd_c;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_v_r;
  assign out_data  = out_r;
  assign cmd       = cmd_c;

  function automatic out_beat_t mk(logic [2:0] k, logic [31:0] id, logic [31:0] lat,
                                   logic [15:0] rq, logic [15:0] ni, logic lst);
    out_beat_t b;
    b.result_kind = k; b.result_id = id; b.latency_ticks = lat;
    b.request_count = rq; b.ids_in_message = ni; b.last_result = lst;
    return b;
  endfunction

  always_comb begin
    state_nxt = state_r; ret_nxt = ret_r; out_nxt = out_r; out_v_nxt = out_v_r;
    hold_nxt = hold_r; n_nxt = n_r; force_nxt = force_r;
    cmd_c.cmd = CMD_NONE;
    if (out_v_r && out_ready) out_v_nxt = 1'b0;
    case (state_r)
      S_IDLE: if (in_valid) begin
        cmd_c.cmd = CMD_LOAD;
        state_nxt = S_DECODE;
      end
      S_DECODE: begin
        case (item_type)
          REQ_DISPATCH: begin
            if (status.in_error || status.full) begin
              hold_nxt = mk(RES_REFUSED, item_id, '0, '0, '0, 1'b1);
            end else begin
              hold_nxt = mk(item_reassigned ? RES_BUILD : RES_PROCESS, item_id,
                            '0, '0, '0, 1'b1);
              cmd_c.cmd = CMD_APPEND;
            end
            ret_nxt = S_IDLE; state_nxt = S_EMIT;
          end
          REQ_TICK: begin
            cmd_c.cmd = CMD_TICK; force_nxt = status.in_error;
            n_nxt = '0; state_nxt = S_POP_WAIT;
          end
          REQ_COMPLETE: begin
            cmd_c.cmd = CMD_MSG_COUNT; state_nxt = S_SCAN_WAIT;
          end
          default: begin
            cmd_c.cmd = CMD_SET_ERROR; force_nxt = 1'b1;
            n_nxt = '0; state_nxt = S_POP_WAIT;
          end
        endcase
      end
      S_POP_WAIT: state_nxt = S_POP_TEST;
      S_POP_TEST: begin
        if (n_r == '0 || !out_v_nxt) begin
          if (status.empty || n_r >= NW'(MAX_RESULTS) ||
              (!force_r && !status.front_expired)) begin
            if (n_r != '0) begin
              out_nxt = hold_r;
              out_nxt.last_result = 1'b1;
              out_v_nxt = 1'b1;
            end
            state_nxt = S_IDLE;
          end else begin
            if (n_r != '0) begin
              out_nxt = hold_r;
              out_v_nxt = 1'b1;
            end
            hold_nxt = mk(RES_REASSIGN, front_id, '0, '0, '0, 1'b0);
            n_nxt = n_r + NW'(1);
            cmd_c.cmd = CMD_POP; state_nxt = S_POP_SHIFT;
          end
        end
      end
      S_POP_SHIFT: begin
        cmd_c.cmd = CMD_REMOVE_STEP;
        if (status.remove_done) state_nxt = S_POP_WAIT;
      end
      S_SCAN_WAIT: begin
        if (status.empty) begin
          hold_nxt = mk(RES_UNKNOWN, item_id, '0, '0, '0, !item_last);
          ret_nxt = item_last ? S_REQ : S_IDLE; state_nxt = S_EMIT;
        end else begin
          cmd_c.cmd = CMD_SCAN_START; state_nxt = S_SCAN_TEST;
        end
      end
      S_SCAN_TEST: begin
        if (status.scan_hit) begin
          hold_nxt = mk(RES_CLEAR, item_id, latency, '0, '0, !item_last);
          state_nxt = S_REMOVE;
        end else if (status.scan_end) begin
          hold_nxt = mk(RES_UNKNOWN, item_id, '0, '0, '0, !item_last);
          ret_nxt = item_last ? S_REQ : S_IDLE; state_nxt = S_EMIT;
        end else begin
          cmd_c.cmd = CMD_SCAN_STEP;
        end
      end
      S_REMOVE: begin
        cmd_c.cmd = CMD_REMOVE_STEP;
        if (status.remove_done) begin
          ret_nxt = item_last ? S_REQ : S_IDLE; state_nxt = S_EMIT;
        end
      end
      S_REQ: begin
        hold_nxt = mk(RES_REQUEST, '0, '0, item_req, msg_count, 1'b1);
        cmd_c.cmd = CMD_MSG_CLEAR;
        ret_nxt = S_IDLE; state_nxt = S_EMIT;
      end
      S_EMIT: if (!out_v_nxt) begin
        out_nxt = hold_r; out_v_nxt = 1'b1; state_nxt = ret_r;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ret_r <= S_IDLE; out_v_r <= 1'b0;
      n_r <= '0; force_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ret_r <= ret_nxt; out_v_r <= out_v_nxt;
      n_r <= n_nxt; force_r <= force_nxt;
    end
    out_r  <= out_nxt;
    hold_r <= hold_nxt;
  end

endmodule

// ===== rtl/core/outstanding_event_timeout_tracker_core.sv =====
// Outstanding event timeout tracker: keeps an ordered list of up to LIST_DEPTH
// dispatched events, reassigns expired ones on ticks (front entries regardless of
// expiry once in error or on a link error), clears them on completion. One beat at
// a time, taken only when idle: a completion searches the entry list serially,
// shifts the entries behind a hit down, and adds a request beat on the last id of
// a message; a tick or link error pops the front entry for each reassignment and
// shifts the rest down. Each result waits in the output register until taken, and
// the next result holds until then.
// Depends on oett_pkg.
module outstanding_event_timeout_tracker_core #(
  parameter int unsigned LIST_DEPTH = oett_pkg::LIST_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  oett_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output oett_pkg::out_beat_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);
  import oett_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic [31:0] item_id, front_id, latency;
  logic [15:0] msg_count, item_req;
  logic        item_reassigned, item_last;
  logic [1:0]  item_type;

  assign cfg_ready = 1'b1;

  oett_datapath #(.LIST_DEPTH(LIST_DEPTH)) u_dp (
    .clk, .rst_n, .cmd, .in_beat(in_data), .cfg_we(cfg_valid), .cfg_data,
    .status, .item_id, .front_id, .latency, .msg_count, .item_reassigned,
    .item_last, .item_req, .item_type
  );

  oett_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data,
    .cmd, .status, .item_id, .front_id, .latency, .msg_count,
    .item_reassigned, .item_last, .item_req, .item_type
  );

endmodule
